// ===== hw/rtl/bsc7s_pkg.sv =====
// Shared types, constants and the segment table of the button-set seven-segment counter.
`default_nettype none

package bsc7s_pkg;

	localparam int VALUE_W    = 14;
	localparam int TICK_W     = 16;
	localparam int BASE_W     = 5;
	localparam int DIGITS     = 4;
	localparam int DIGIT_W    = 4;
	localparam int SEG_W      = 8;
	localparam int SW_W       = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = $clog2(VALUE_W + 1);

	localparam logic [VALUE_W-1:0] VALUE_RESET    = 14'd5678;
	localparam logic [VALUE_W-1:0] VALUE_MODULUS  = 14'd10000;
	localparam logic [BASE_W-1:0]  BASE_RESET     = 5'd10;
	localparam logic [BASE_W-1:0]  BASE_MIN       = 5'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX       = 5'd16;
	localparam logic [TICK_W-1:0]  INTERVAL_RESET = 16'd5;
	localparam logic [TICK_W-1:0]  TICK_MAX       = 16'hFFFF;
	localparam logic [SEG_W-1:0]   SEG_BLANK      = 8'hFF;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUMBER_BASE     = 1'b0,
		CFG_REPEAT_INTERVAL = 1'b1
	} cfg_reg_t;

	// Request kinds
	typedef enum logic {
		REQ_TICK   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [DIGITS-1:0][DIGIT_W-1:0] digits;
		logic                           ovf;
	} conv_res_t;

	function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'h0: s = 8'h82;
			4'h1: s = 8'hbb;
			4'h2: s = 8'h85;
			4'h3: s = 8'h91;
			4'h4: s = 8'hb8;
			4'h5: s = 8'hd0;
			4'h6: s = 8'hc0;
			4'h7: s = 8'h9b;
			4'h8: s = 8'h80;
			4'h9: s = 8'h90;
			4'ha: s = 8'h88;
			4'hb: s = 8'he0;
			4'hc: s = 8'hc6;
			4'hd: s = 8'ha1;
			4'he: s = 8'hc4;
			default: s = 8'hcc;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bsc7s_ifs.sv =====
// Request and result channel interfaces of the button-set seven-segment counter.
`default_nettype none

interface bsc7s_req_if;
	import bsc7s_pkg::*;
	logic            valid;
	logic            ready;
	logic            req_type;
	logic [SW_W-1:0] switches_pressed;
	modport source(output valid, req_type, switches_pressed, input ready);
	modport sink(input valid, req_type, switches_pressed, output ready);
endinterface

interface bsc7s_res_if;
	import bsc7s_pkg::*;
	logic               valid;
	logic               ready;
	logic [SEG_W-1:0]   digit0_segments;
	logic [SEG_W-1:0]   digit1_segments;
	logic [SEG_W-1:0]   digit2_segments;
	logic [SEG_W-1:0]   digit3_segments;
	logic [DIGITS-1:0]  digit_enables;
	logic [VALUE_W-1:0] shown_value_out;
	modport source(output valid, digit0_segments, digit1_segments, digit2_segments,
		digit3_segments, digit_enables, shown_value_out, input ready);
	modport sink(input valid, digit0_segments, digit1_segments, digit2_segments,
		digit3_segments, digit_enables, shown_value_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bsc7s_digit_conv.sv =====
// Bit-serial radix converter: shifts the value in MSB first into four base-b digits.
`default_nettype none

module bsc7s_digit_conv (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [bsc7s_pkg::VALUE_W-1:0] value,
	input  wire logic [bsc7s_pkg::BASE_W-1:0]  base,
	output logic                               done,
	output bsc7s_pkg::conv_res_t               result
);
	import bsc7s_pkg::*;

	logic [VALUE_W-1:0]             n_q;
	logic [DIGITS-1:0][DIGIT_W-1:0] dig_q;
	logic [DIGITS-1:0][DIGIT_W-1:0] dig_d;
	logic                           ovf_q;
	logic                           ovf_d;
	logic [CNT_W-1:0]               cnt_q;
	logic                           busy_q;

	// Digits = digits*2 + incoming bit, carry ripples up through four narrow stages
	always_comb begin
		logic             carry;
		logic [DIGIT_W:0] t;
		carry = n_q[VALUE_W-1];
		for (int k = 0; k < DIGITS; k++) begin
			t = {dig_q[k], carry};
			if (t >= base) begin
				dig_d[k] = DIGIT_W'(t - base);
				carry    = 1'b1;
			end else begin
				dig_d[k] = t[DIGIT_W-1:0];
				carry    = 1'b0;
			end
		end
		ovf_d = ovf_q | carry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(VALUE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= value;
			dig_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= {n_q[VALUE_W-2:0], 1'b0};
			dig_q <= dig_d;
			ovf_q <= ovf_d;
		end
	end

	assign done          = busy_q && (cnt_q == CNT_W'(1));
	assign result.digits = dig_q;
	assign result.ovf    = ovf_q;

endmodule

`default_nettype wire

// ===== hw/rtl/button_set_counter_seven_segment.sv =====
// Top level of the button-set four-digit seven-segment counter.
//
// Channels: req carries one request per handshake (valid && ready): req_type 0 is a
// timer tick, 1 a switch sample with switches_pressed. res carries one result per
// request: four segment bytes, the digit enables and the value after the request.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 number_base,
// 1 repeat_interval) at a clock edge; write only while no request is in flight.
// Timing: a request updates value and tick count in its accept cycle, then the
// serial converter shifts the 14 value bits into four base-b digits, one bit per
// cycle, and the result register loads once the conversion is done and the register
// is free. A new request is taken only after the result register has loaded.
// One request is in work at a time; req.ready is high in the idle state, so the next
// request may enter while the previous result still waits in the result register.
// Stall: if res is not taken, a finished conversion waits until the result register
// frees up, and req.ready stays low meanwhile.
// Reset (arst_n low): value 5678, tick count 0, base 10, repeat interval 5, no
// result pending.
`default_nettype none

module button_set_counter_seven_segment (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bsc7s_req_if.sink                             req,
	bsc7s_res_if.source                           res,
	input  wire logic                             cfg_we,
	input  wire logic [bsc7s_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bsc7s_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bsc7s_pkg::*;

	localparam logic [VALUE_W-1:0] ADD_THOUSAND = 14'd1000;
	localparam logic [VALUE_W-1:0] ADD_HUNDRED  = 14'd100;
	localparam logic [VALUE_W-1:0] ADD_TEN      = 14'd10;
	localparam logic [VALUE_W-1:0] ADD_ONE      = 14'd1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;

	logic [BASE_W-1:0]  base_q;
	logic [TICK_W-1:0]  interval_q;
	logic [VALUE_W-1:0] value_q;
	logic [TICK_W-1:0]  ticks_q;

	logic [VALUE_W-1:0] value_d;
	logic [TICK_W-1:0]  ticks_d;
	logic [BASE_W-1:0]  eff_base;
	logic               accept;
	logic               conv_done;
	conv_res_t          conv_res;
	logic               res_load;

	logic                         res_valid_q;
	logic [DIGITS-1:0][SEG_W-1:0] segs_q;
	logic [DIGITS-1:0]            en_q;
	logic [VALUE_W-1:0]           shown_q;
	logic [DIGITS-1:0]            en_d;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Clamp the radix into 2..16
	always_comb begin
		if (base_q < BASE_MIN) begin
			eff_base = BASE_MIN;
		end else if (base_q > BASE_MAX) begin
			eff_base = BASE_MAX;
		end else begin
			eff_base = base_q;
		end
	end

	// Next value and tick count for the request at the port
	always_comb begin
		logic [VALUE_W-1:0] addend;
		logic               hit;
		logic               clr;
		logic [VALUE_W-1:0] sum;
		addend  = '0;
		hit     = 1'b1;
		clr     = 1'b0;
		value_d = value_q;
		ticks_d = ticks_q;
		if (req.switches_pressed[0]) begin
			addend = ADD_THOUSAND;
		end else if (req.switches_pressed[1]) begin
			addend = ADD_HUNDRED;
		end else if (req.switches_pressed[2]) begin
			addend = ADD_TEN;
		end else if (req.switches_pressed[3]) begin
			addend = ADD_ONE;
		end else if (req.switches_pressed[7]) begin
			clr = 1'b1;
		end else begin
			hit = 1'b0;
		end
		// value + 1000 stays below 2**14, so one subtract wraps it
		sum = value_q + addend;
		if (sum >= VALUE_MODULUS) begin
			sum = sum - VALUE_MODULUS;
		end
		if (req.req_type == REQ_TICK) begin
			if (ticks_q != TICK_MAX) begin
				ticks_d = ticks_q + 1'b1;
			end
		end else if (ticks_q > interval_q && hit) begin
			value_d = clr ? '0 : sum;
			ticks_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= BASE_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_NUMBER_BASE:     base_q     <= cfg_data[BASE_W-1:0];
				CFG_REPEAT_INTERVAL: interval_q <= cfg_data[TICK_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= VALUE_RESET;
			ticks_q <= '0;
		end else if (accept) begin
			value_q <= value_d;
			ticks_q <= ticks_d;
		end
	end

	bsc7s_digit_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (value_d),
		.base   (eff_base),
		.done   (conv_done),
		.result (conv_res)
	);

	// Load the result register once it is empty or being drained
	assign res_load = (state_q == ST_HOLD) && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CONV;
				ST_CONV: if (conv_done) state_q <= ST_HOLD;
				ST_HOLD: if (res_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Blank leading zeros; digits beyond the fourth keep every display lit
	always_comb begin
		en_d[3] = conv_res.ovf || (conv_res.digits[3] != '0);
		en_d[2] = en_d[3] || (conv_res.digits[2] != '0);
		en_d[1] = en_d[2] || (conv_res.digits[1] != '0);
		en_d[0] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			for (int k = 0; k < DIGITS; k++) begin
				segs_q[k] <= en_d[k] ? seg_code(conv_res.digits[k]) : SEG_BLANK;
			end
			en_q    <= en_d;
			shown_q <= value_q;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.digit0_segments = segs_q[0];
	assign res.digit1_segments = segs_q[1];
	assign res.digit2_segments = segs_q[2];
	assign res.digit3_segments = segs_q[3];
	assign res.digit_enables   = en_q;
	assign res.shown_value_out = shown_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bsc7s_checker.sv =====
// Port-level checker of the button-set seven-segment counter and its bind.
`default_nettype none

module bsc7s_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] digit0_segments,
	input wire logic [3:0] digit_enables,
	input wire logic [13:0] shown_value_out
);

	// Hold a result until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// One request in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> shown_value_out <= 14'd9999)
		else $error("shown value out of range");

	// Enables fill from the lowest display upward
	a_enables_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (digit_enables == 4'h1 || digit_enables == 4'h3 ||
			digit_enables == 4'h7 || digit_enables == 4'hf))
		else $error("digit enables not contiguous");

	a_zero_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && shown_value_out == 14'd0 |->
			digit_enables == 4'h1 && digit0_segments == 8'h82)
		else $error("zero not shown as single digit");

endmodule

bind button_set_counter_seven_segment bsc7s_checker u_bsc7s_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.digit0_segments (res.digit0_segments),
	.digit_enables   (res.digit_enables),
	.shown_value_out (res.shown_value_out)
);

`default_nettype wire

// ===== bench/tb_button_set_counter_seven_segment.sv =====
// Self-checking testbench of the button-set four-digit seven-segment counter.
module tb_button_set_counter_seven_segment;
	timeunit 1ns;
	timeprecision 1ps;

	import bsc7s_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int LATENCY       = 16;
	localparam int IDLE_LIMIT    = 1000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 65;

	// Active-low segment bytes for digit values 0 to 15
	localparam logic [SEG_W-1:0] DIGIT_GLYPH [16] = '{
		8'h82, 8'hbb, 8'h85, 8'h91, 8'hb8, 8'hd0, 8'hc0, 8'h9b,
		8'h80, 8'h90, 8'h88, 8'he0, 8'hc6, 8'ha1, 8'hc4, 8'hcc
	};

	// One display frame as the block reports it after a request
	typedef struct packed {
		logic [SEG_W-1:0]   seg0, seg1, seg2, seg3;
		logic [DIGITS-1:0]  enables;
		logic [VALUE_W-1:0] value;
	} display_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bsc7s_req_if req_ch ();
	bsc7s_res_if res_ch ();

	// Predictor state: the counter and its configuration as the block should hold them
	int unsigned       counter_value;
	int unsigned       ticks_seen;
	logic [BASE_W-1:0] base_reg;
	logic [TICK_W-1:0] interval_reg;

	// Frames still owed by the block, oldest first
	display_t expected_displays [$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	bit no_idle        = 1'b0;

	button_set_counter_seven_segment u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Split the value into four digits in the current base, blank leading zeros,
	// but always show the lowest digit so that zero reads as a single 0.
	function automatic display_t render_display(int unsigned value);
		display_t         frame;
		logic [SEG_W-1:0] segs [DIGITS];
		int unsigned      radix;
		int unsigned      rest;
		radix = (base_reg < BASE_MIN) ? BASE_MIN : (base_reg > BASE_MAX) ? BASE_MAX : base_reg;
		rest = value;
		frame.enables = '0;
		for (int k = 0; k < DIGITS; k++) begin
			if (rest != 0 || k == 0) begin
				segs[k] = DIGIT_GLYPH[(rest % radix) & 15];
				frame.enables[k] = 1'b1;
				rest = rest / radix;
			end else begin
				segs[k] = SEG_BLANK;
			end
		end
		frame.seg0 = segs[0];
		frame.seg1 = segs[1];
		frame.seg2 = segs[2];
		frame.seg3 = segs[3];
		frame.value = value[VALUE_W-1:0];
		return frame;
	endfunction

	// Advance the predicted counter by one accepted request and queue the frame it shows.
	function automatic void apply_request(req_kind_t kind, logic [SW_W-1:0] sw);
		int unsigned sum;
		bit          acted;
		if (kind == REQ_TICK) begin
			// saturate the tick count instead of wrapping
			if (ticks_seen < TICK_MAX)
				ticks_seen++;
		end else if (ticks_seen > interval_reg) begin
			// first pressed switch wins: 0, 1, 2, 3, then 7 clears
			acted = 1'b1;
			sum = counter_value;
			if (sw[0])
				sum += 1000;
			else if (sw[1])
				sum += 100;
			else if (sw[2])
				sum += 10;
			else if (sw[3])
				sum += 1;
			else if (sw[7])
				sum = 0;
			else
				acted = 1'b0;
			if (acted) begin
				counter_value = sum % VALUE_MODULUS;
				ticks_seen = 0;
			end
		end
		expected_displays.push_back(render_display(counter_value));
	endfunction

	// Mostly short gaps, a few long ones, none while a steady stretch runs.
	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	// Send one request. Called and returns at a falling edge; valid stays high
	// on return so back-to-back requests need no extra edge.
	task automatic send_request(input req_kind_t kind, input logic [SW_W-1:0] sw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			// drop valid and put junk on the payload during the gap
			req_ch.valid <= 1'b0;
			req_ch.req_type <= 1'($urandom);
			req_ch.switches_pressed <= SW_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.switches_pressed <= sw;
		do
			@(posedge clk);
		while (!req_ch.ready);
		apply_request(kind, sw);
		@(negedge clk);
	endtask

	// Drop valid and hold until every owed frame has come back.
	task automatic wait_until_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_displays.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Write one register; only call with the block drained.
	task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_NUMBER_BASE)
			base_reg = data[BASE_W-1:0];
		else
			interval_reg = data;
		@(negedge clk);
	endtask

	// A press right after reset falls inside the repeat interval and must be ignored.
	task automatic test_reset_guard();
		send_request(REQ_SAMPLE, 8'h01);
		wait_until_drained();
		write_register(CFG_REPEAT_INTERVAL, '0);
	endtask

	// Walk the value past 9999 with the thousands switch, then check the
	// priority order with lower-priority switches held down alongside.
	task automatic test_press_priority();
		for (int i = 0; i < 5; i++) begin
			send_request(REQ_TICK, 8'h00);
			send_request(REQ_SAMPLE, (i < 4) ? 8'h01 : 8'hFF);
		end
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_SAMPLE, 8'hFE);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_SAMPLE, 8'hFC);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_SAMPLE, 8'hF8);
		// only unused switches pressed: nothing changes
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_SAMPLE, 8'h70);
	endtask

	// Bases outside 2..16 clamp; base 2 needs more than four digits for the value.
	task automatic test_base_extremes();
		logic [BASE_W-1:0] odd_bases [4];
		odd_bases = '{5'd0, 5'd1, 5'd17, 5'd31};
		foreach (odd_bases[i]) begin
			wait_until_drained();
			// upper data bits are not part of the base register
			write_register(CFG_NUMBER_BASE, {11'h7FF, odd_bases[i]});
			send_request(REQ_TICK, 8'hFF);
		end
	endtask

	// Clear to zero shows a lone 0, and an empty sample leaves it there.
	task automatic test_clear_to_zero();
		wait_until_drained();
		write_register(CFG_NUMBER_BASE, 16'(BASE_RESET));
		send_request(REQ_SAMPLE, 8'h80);
		send_request(REQ_SAMPLE, 8'h00);
	endtask

	// Random phases: each sets a base and an interval, then mixes ticks with
	// presses of one chosen switch, raw switch bytes and empty samples.
	task automatic test_random_presses();
		logic [BASE_W-1:0] radix;
		logic [TICK_W-1:0] interval;
		logic [SW_W-1:0]   sw;
		int                roll;
		int                pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					radix = BASE_MIN;
					interval = '0;
				end
				1: begin
					// switches locked out for good
					radix = BASE_MAX;
					interval = TICK_MAX;
				end
				2: begin
					radix = BASE_RESET;
					interval = TICK_MAX - 1;
				end
				3: begin
					radix = 5'd31;
					interval = 16'd1;
				end
				default: begin
					radix = ($urandom_range(0, 3) == 0) ? BASE_W'($urandom_range(0, 31))
						: BASE_W'($urandom_range(2, 16));
					interval = TICK_W'($urandom_range(0, 8));
				end
			endcase
			wait_until_drained();
			no_idle = (phase % 4 == 3);
			write_register(CFG_NUMBER_BASE, {CFG_DATA_W'($urandom)} & ~16'h1F | radix);
			write_register(CFG_REPEAT_INTERVAL, interval);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					send_request(REQ_TICK, SW_W'($urandom));
				end else if (roll < 75) begin
					// press one switch, with only lower-priority ones also down
					pick = $urandom_range(0, 4);
					sw = SW_W'($urandom);
					case (pick)
						0: sw[0] = 1'b1;
						1: sw[1:0] = 2'b10;
						2: sw[2:0] = 3'b100;
						3: sw[3:0] = 4'b1000;
						default: begin
							sw[3:0] = 4'b0000;
							sw[7] = 1'b1;
						end
					endcase
					send_request(REQ_SAMPLE, sw);
				end else if (roll < 90) begin
					send_request(REQ_SAMPLE, SW_W'($urandom));
				end else begin
					send_request(REQ_SAMPLE, {1'b0, 3'($urandom), 4'b0000});
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// Result side: stall ready with the same gap profile as the request side.
	initial begin : result_pacing
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0)
				stall--;
			else
				stall = pick_gap();
			res_ch.ready <= (stall == 0);
		end
	end

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s expected 0x%0h got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Match every accepted frame against the oldest owed one.
	always @(posedge clk) begin : result_check
		display_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_displays.size() == 0) begin
				$error("frame with no request owed: shown_value_out %0d", res_ch.shown_value_out);
				mismatch_count++;
			end else begin
				want = expected_displays.pop_front();
				compare_field("digit0_segments", want.seg0, res_ch.digit0_segments);
				compare_field("digit1_segments", want.seg1, res_ch.digit1_segments);
				compare_field("digit2_segments", want.seg2, res_ch.digit2_segments);
				compare_field("digit3_segments", want.seg3, res_ch.digit3_segments);
				compare_field("digit_enables", want.enables, res_ch.digit_enables);
				compare_field("shown_value_out", want.value, res_ch.shown_value_out);
			end
		end
	end

	// Stop a hung run: count cycles in which neither channel moves a word.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("button_set_counter_seven_segment verification failed");
				$finish;
			end
		end
	end

	initial begin
		// drive every input to a known value before the first edge
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.switches_pressed = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_NUMBER_BASE;
		cfg_data = '0;
		counter_value = VALUE_RESET;
		ticks_seen = 0;
		base_reg = BASE_RESET;
		interval_reg = INTERVAL_RESET;

		// hold reset, then release it away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_guard();
		test_press_priority();
		test_base_extremes();
		test_clear_to_zero();
		test_random_presses();

		// drain the last frames, then give any stray frame time to show up
		wait_until_drained();
		repeat (LATENCY + 4) @(negedge clk);

		if (mismatch_count == 0)
			$display("button_set_counter_seven_segment verification clean");
		else
			$display("button_set_counter_seven_segment verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/bsc7s_pkg.sv
hw/rtl/bsc7s_ifs.sv
hw/rtl/bsc7s_digit_conv.sv
hw/rtl/button_set_counter_seven_segment.sv
hw/rtl/bsc7s_checker.sv
bench/tb_button_set_counter_seven_segment.sv
